@@ design/rgb_convolution_3x3_assert.svh @@
// ----------------------------------------------------------------------------
// RGB 3x3 convolution assertion macros
// Shared property forms for the checker of the convolution block.
// ----------------------------------------------------------------------------
`ifndef RGB_CONVOLUTION_3X3_ASSERT_SVH
`define RGB_CONVOLUTION_3X3_ASSERT_SVH

// Same-cycle implication.
`define RC3_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define RC3_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/rc3_pkg.sv @@
// ----------------------------------------------------------------------------
// RGB 3x3 convolution package
// Widths, codes and the word that travels down the divider chain.
// ----------------------------------------------------------------------------
package rc3_pkg;

   localparam int LANES = 3;
   localparam int PIX_W = 8;
   localparam int SUM_W = 21;
   localparam int TOT_W = 12;
   localparam int DVD_W = 20;
   localparam int DIV_W = 11;

   typedef logic [2:0] csr_index_type;

   localparam csr_index_type CSR_COEF_A = 3'd0;
   localparam csr_index_type CSR_COEF_B = 3'd1;
   localparam csr_index_type CSR_COEF_C = 3'd2;
   localparam csr_index_type CSR_ABS    = 3'd3;
   localparam csr_index_type CSR_WIDTH  = 3'd4;
   localparam csr_index_type CSR_HEIGHT = 3'd5;

   localparam logic ACT_PUSH  = 1'b0;
   localparam logic ACT_DRAIN = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_FLUSH,
      ST_LAUNCH,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [LANES-1:0][DVD_W-1:0] num;
      logic [LANES-1:0][DIV_W-1:0] rem;
      logic [DIV_W-1:0]            den;
      logic [LANES-1:0]            neg;
      logic                        abs_mode;
      logic                        last;
   } div_word_type;

endpackage

@@ design/rc3_div_cell.sv @@
// ----------------------------------------------------------------------------
// Divider cell
// One restoring step on three lanes: develops one quotient bit per lane.
// ----------------------------------------------------------------------------
module rc3_div_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  rc3_pkg::div_word_type in_word,
   output logic                 out_valid,
   output rc3_pkg::div_word_type out_word
);
   import rc3_pkg::*;

   logic         valid_ff;
   div_word_type word_ff;
   div_word_type word_in;
   logic [DIV_W:0] trial [LANES];
   logic [DIV_W:0] diff [LANES];
   logic           fits [LANES];

   always_comb begin
      word_in = in_word;
      for (int l = 0; l < LANES; l++) begin
         trial[l] = {in_word.rem[l], in_word.num[l][DVD_W-1]};
         diff[l] = trial[l] - {1'b0, in_word.den};
         fits[l] = trial[l] >= {1'b0, in_word.den};
         word_in.rem[l] = fits[l] ? diff[l][DIV_W-1:0] : trial[l][DIV_W-1:0];
         word_in.num[l] = {in_word.num[l][DVD_W-2:0], fits[l]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

@@ design/rc3_div_chain.sv @@
// ----------------------------------------------------------------------------
// Divider chain
// A row of divider cells; the quotient magnitude leaves the last cell.
// ----------------------------------------------------------------------------
module rc3_div_chain (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  rc3_pkg::div_word_type in_word,
   output logic                 out_valid,
   output rc3_pkg::div_word_type out_word
);
   import rc3_pkg::*;

   logic         vld [DVD_W+1];
   div_word_type word [DVD_W+1];

   assign vld[0]  = in_valid;
   assign word[0] = in_word;

   for (genvar i = 0; i < DVD_W; i++) begin : g_cell
      rc3_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (vld[i]),
         .in_word   (word[i]),
         .out_valid (vld[i+1]),
         .out_word  (word[i+1])
      );
   end

   assign out_valid = vld[DVD_W];
   assign out_word  = word[DVD_W];

endmodule

@@ design/rgb_convolution_3x3.sv @@
// ----------------------------------------------------------------------------
// RGB 3x3 convolution
// Streaming 3x3 integer kernel on RGB pixels with normalization.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the req stream; tuser selects a pixel push
// or a drain. A push stores the pixel in a three-row store and, once two rows
// and two pixels are in, releases one filtered pixel. After the frame is in,
// each drain releases one more pixel until the frame ends with tlast.
// The csr channel is always ready and must be written only while idle.
// Writing the width or height restarts the frame.
// An item that releases nothing leaves the block ready for the next item. An
// item that releases a pixel reads nine taps in turn through the single store
// read port and then passes a 20-cell divider chain; the next item is taken
// only once that result has moved into the rsp register.
// A finished result waits in the rsp register while the next item is taken.
// When the receiver stalls, the following result waits inside the block.
// Reset restores the register defaults and empties the frame; the row store
// is not cleared, and no pixel is read before it was written.
// ----------------------------------------------------------------------------
module rgb_convolution_3x3 #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,   // in_red, in_green, in_blue
   input  logic                  req_tuser,   // action
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,   // out_red, out_green, out_blue
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  rc3_pkg::csr_index_type csr_index,
   input  logic [23:0]           csr_data
);
   import rc3_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int W_RST = ((MAX_WIDTH < 1024) ? MAX_WIDTH : 1024) - 1;
   localparam int H_RST = ((MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024) - 1;

   function automatic logic [CW-1:0] last_col(input logic [10:0] v);
      logic [CW-1:0] r;
      if (v < 11'd2) r = CW'(1);
      else if (32'(v) > MAX_WIDTH) r = CW'(MAX_WIDTH - 1);
      else r = CW'(v - 11'd1);
      return r;
   endfunction

   function automatic logic [RW-1:0] last_row(input logic [10:0] v);
      logic [RW-1:0] r;
      if (v < 11'd2) r = RW'(1);
      else if (32'(v) > MAX_HEIGHT) r = RW'(MAX_HEIGHT - 1);
      else r = RW'(v - 11'd1);
      return r;
   endfunction

   function automatic logic [1:0] inc3(input logic [1:0] v);
      return (v == 2'd2) ? 2'd0 : v + 2'd1;
   endfunction

   logic [2:0][23:0] coef_ff;
   logic             abs_ff;
   logic [CW-1:0]    wlast_ff;
   logic [RW-1:0]    hlast_ff;

   state_type state_ff, state_in;

   logic [CW-1:0] in_col_ff, in_col_in;
   logic [RW-1:0] in_row_ff, in_row_in;
   logic [1:0]    in_r3_ff, in_r3_in;
   logic          in_full_ff, in_full_in;
   logic [CW-1:0] out_col_ff, out_col_in;
   logic [RW-1:0] out_row_ff, out_row_in;
   logic [1:0]    out_r3_ff, out_r3_in;

   logic [CW-1:0] cur_c_ff;
   logic [RW-1:0] cur_r_ff;
   logic [1:0]    cur_r3_ff;
   logic          cur_last_ff;
   logic [1:0]    dx_ff, dx_in;
   logic [1:0]    dy_ff, dy_in;

   logic [23:0]   row_store_ff [3][MAX_WIDTH];
   logic [23:0]   rd_ff;
   logic          rd_vld_ff;
   logic [1:0]    rd_dx_ff;
   logic [1:0]    rd_dy_ff;

   logic signed [SUM_W-1:0] acc_ff [LANES];
   logic signed [TOT_W-1:0] tot_ff;

   logic [23:0] res_ff;
   logic        res_last_ff;
   logic        rsp_valid_ff;
   logic [23:0] rsp_data_ff;
   logic        rsp_last_ff;

   logic accept, push_ok, drain_ok, lag_ok, emit, out_last, geo_write, rsp_load;

   logic [CW:0]   col_sum;
   logic [CW-1:0] col_sel;
   logic [RW:0]   row_sum;
   logic [2:0]    r3_sum;
   logic [1:0]    r3_sel;

   logic signed [7:0]       coef_sel;
   logic signed [16:0]      prod [LANES];
   logic signed [TOT_W-1:0] tot_fix, tot_mag;
   logic                    tot_neg;
   logic signed [SUM_W-1:0] sum_mag [LANES];
   div_word_type            launch_word, chain_word;
   logic                    launch_valid, chain_valid;
   logic [23:0]             res_in;

   assign csr_ready = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept = req_tvalid && req_tready;
   assign push_ok = accept && (req_tuser == ACT_PUSH) && !in_full_ff;
   assign drain_ok = accept && (req_tuser == ACT_DRAIN) && in_full_ff;
   assign lag_ok = (in_row_ff > 2) || ((in_row_ff == 2) && (in_col_ff >= 2));
   assign emit = (push_ok && lag_ok) || drain_ok;
   assign out_last = (out_col_ff == wlast_ff) && (out_row_ff == hlast_ff);
   assign geo_write = csr_valid && ((csr_index == CSR_WIDTH) || (csr_index == CSR_HEIGHT));

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff  <= '0;
         abs_ff   <= 1'b0;
         wlast_ff <= CW'(W_RST);
         hlast_ff <= RW'(H_RST);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_COEF_A: coef_ff[0] <= csr_data;
            CSR_COEF_B: coef_ff[1] <= csr_data;
            CSR_COEF_C: coef_ff[2] <= csr_data;
            CSR_ABS:    abs_ff <= csr_data[0];
            CSR_WIDTH:  wlast_ff <= last_col(csr_data[10:0]);
            CSR_HEIGHT: hlast_ff <= last_row(csr_data[10:0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      in_r3_in   = in_r3_ff;
      in_full_in = in_full_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      out_r3_in  = out_r3_ff;
      priority if (geo_write || (drain_ok && out_last)) begin
         in_col_in  = '0;
         in_row_in  = '0;
         in_r3_in   = '0;
         in_full_in = 1'b0;
         out_col_in = '0;
         out_row_in = '0;
         out_r3_in  = '0;
      end else begin
         if (push_ok) begin
            if (in_col_ff == wlast_ff) begin
               in_col_in = '0;
               if (in_row_ff == hlast_ff) begin
                  in_row_in  = '0;
                  in_r3_in   = '0;
                  in_full_in = 1'b1;
               end else begin
                  in_row_in = in_row_ff + RW'(1);
                  in_r3_in  = inc3(in_r3_ff);
               end
            end else begin
               in_col_in = in_col_ff + CW'(1);
            end
         end
         if (emit) begin
            if (out_col_ff == wlast_ff) begin
               out_col_in = '0;
               out_row_in = out_row_ff + RW'(1);
               out_r3_in  = inc3(out_r3_ff);
            end else begin
               out_col_in = out_col_ff + CW'(1);
            end
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      launch_valid = 1'b0;
      rsp_load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            dx_in = '0;
            dy_in = '0;
            if (emit) state_in = ST_READ;
         end
         ST_READ: begin
            if (dy_ff == 2'd2) begin
               dy_in = '0;
               dx_in = dx_ff + 2'd1;
               if (dx_ff == 2'd2) state_in = ST_FLUSH;
            end else begin
               dy_in = dy_ff + 2'd1;
            end
         end
         ST_FLUSH: state_in = ST_LAUNCH;
         ST_LAUNCH: begin
            launch_valid = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (chain_valid) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_r3_ff    <= '0;
         in_full_ff  <= 1'b0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_r3_ff   <= '0;
         dx_ff       <= '0;
         dy_ff       <= '0;
         rd_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         in_r3_ff    <= in_r3_in;
         in_full_ff  <= in_full_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         out_r3_ff   <= out_r3_in;
         dx_ff       <= dx_in;
         dy_ff       <= dy_in;
         rd_vld_ff   <= (state_ff == ST_READ);
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // Tap address: columns and rows past the frame edge fold back to the
   // second-to-last one.
   always_comb begin
      col_sum = {1'b0, cur_c_ff} + (CW+1)'(dx_ff);
      col_sel = (col_sum > {1'b0, wlast_ff}) ? wlast_ff - CW'(1) : col_sum[CW-1:0];
      row_sum = {1'b0, cur_r_ff} + (RW+1)'(dy_ff);
      r3_sum  = {1'b0, cur_r3_ff} + {1'b0, dy_ff};
      if (row_sum > {1'b0, hlast_ff}) begin
         if (cur_r_ff == hlast_ff) r3_sel = (cur_r3_ff == 2'd0) ? 2'd2 : cur_r3_ff - 2'd1;
         else r3_sel = cur_r3_ff;
      end else begin
         r3_sel = (r3_sum >= 3'd3) ? 2'(r3_sum - 3'd3) : r3_sum[1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) row_store_ff[in_r3_ff][in_col_ff] <= req_tdata;
      if (state_ff == ST_READ) rd_ff <= row_store_ff[r3_sel][col_sel];
      rd_dx_ff <= dx_ff;
      rd_dy_ff <= dy_ff;
      if (accept) begin
         cur_c_ff    <= out_col_ff;
         cur_r_ff    <= out_row_ff;
         cur_r3_ff   <= out_r3_ff;
         cur_last_ff <= out_last;
      end
   end

   always_comb begin
      coef_sel = $signed(coef_ff[rd_dx_ff][{rd_dy_ff, 3'b000} +: 8]);
      for (int l = 0; l < LANES; l++) begin
         prod[l] = $signed({1'b0, rd_ff[PIX_W*l +: PIX_W]}) * coef_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tot_ff <= '0;
         for (int l = 0; l < LANES; l++) acc_ff[l] <= '0;
      end else if (rd_vld_ff) begin
         tot_ff <= tot_ff + TOT_W'(coef_sel);
         for (int l = 0; l < LANES; l++) acc_ff[l] <= acc_ff[l] + SUM_W'(prod[l]);
      end
   end

   always_comb begin
      tot_fix = (tot_ff == '0) ? TOT_W'(1) : tot_ff;
      tot_neg = tot_fix[TOT_W-1];
      tot_mag = tot_neg ? -tot_fix : tot_fix;
      launch_word.den      = tot_mag[DIV_W-1:0];
      launch_word.abs_mode = abs_ff;
      launch_word.last     = cur_last_ff;
      for (int l = 0; l < LANES; l++) begin
         sum_mag[l] = acc_ff[l][SUM_W-1] ? -acc_ff[l] : acc_ff[l];
         launch_word.num[l] = sum_mag[l][DVD_W-1:0];
         launch_word.rem[l] = '0;
         launch_word.neg[l] = acc_ff[l][SUM_W-1] ^ tot_neg;
      end
   end

   rc3_div_chain u_div_chain (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (launch_valid),
      .in_word   (launch_word),
      .out_valid (chain_valid),
      .out_word  (chain_word)
   );

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         if (chain_word.neg[l] && !chain_word.abs_mode) res_in[PIX_W*l +: PIX_W] = '0;
         else if (|chain_word.num[l][DVD_W-1:PIX_W]) res_in[PIX_W*l +: PIX_W] = 8'hFF;
         else res_in[PIX_W*l +: PIX_W] = chain_word.num[l][PIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DIV && chain_valid) begin
         res_ff      <= res_in;
         res_last_ff <= chain_word.last;
      end
      if (rsp_load) begin
         rsp_data_ff <= res_ff;
         rsp_last_ff <= res_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ design/rc3_checker.sv @@
// ----------------------------------------------------------------------------
// RGB 3x3 convolution checker
// Port-level properties of the convolution block, bound to the top level.
// ----------------------------------------------------------------------------
`include "rgb_convolution_3x3_assert.svh"

module rc3_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        csr_valid,
   input logic        csr_ready
);

   `RC3_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "rsp changed while stalled")

   `RC3_ASSERT_IMP(a_rsp_after_busy, clock, reset, $rose(rsp_tvalid), !$past(req_tready), "result appeared while input side was idle")

   `RC3_ASSERT_NXT(a_no_fast_result, clock, reset, req_tvalid && req_tready, !$rose(rsp_tvalid), "result one cycle after a transfer")

   `RC3_ASSERT_IMP(a_csr_ready, clock, reset, csr_valid, csr_ready, "csr transfer refused")

endmodule

bind rgb_convolution_3x3 rc3_checker u_rc3_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready)
);
